FILE: rtl/prime_factorizer_macros.svh
// Assertion macros used by the prime factorizer RTL.
`ifndef PRIME_FACTORIZER_MACROS_SVH
`define PRIME_FACTORIZER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/pf_pkg.sv
// Shared widths and types of the prime factorizer.
package pf_pkg;
    localparam int NUMBER_WIDTH = 14;
    localparam int CNT_W        = (NUMBER_WIDTH > 2) ? $clog2(NUMBER_WIDTH) : 1;

    typedef logic [NUMBER_WIDTH-1:0] t_num;
    typedef logic [CNT_W-1:0]        t_cnt;
endpackage

FILE: rtl/pf_if.sv
// Valid/ready channel interfaces for the number input and the factor output.
interface pf_num_if;
    import pf_pkg::*;
    logic valid;
    logic ready;
    t_num number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface pf_fac_if;
    import pf_pkg::*;
    logic valid;
    logic ready;
    t_num factor;
    logic last;

    modport source (output valid, output factor, output last, input ready);
    modport sink   (input valid, input factor, input last, output ready);
endinterface

FILE: rtl/prime_factorizer.sv
// Prime factorizer top level: trial division with a bit-serial restoring divider.
// Usage:
//   i_num (valid/ready) takes one unsigned number per transfer. o_fac (valid/ready)
//   returns its prime factors in ascending order, one per transfer, repeated per
//   multiplicity, with last set on the final one. An input of 0 or 1 returns a
//   single factor of 0 with last set.
// Timing:
//   Each trial division shifts the dividend through the divider one bit per
//   cycle. Trials stop once the divisor exceeds the quotient, so an input needs
//   at most about sqrt(number) trials plus one per factor found.
//   One number is worked on at a time; i_num.ready is high only when idle. The
//   next number can be taken while the final factor still waits in the output
//   register.
// Reset:
//   Synchronous, active low; the block returns to idle and drops o_fac.valid.
// Stall:
//   If o_fac.ready is low the factor holds in the output register; the search
//   goes on and pauses only at its next factor, until that transfer completes.
module prime_factorizer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pf_num_if.sink   i_num,
    pf_fac_if.source o_fac
);
    import pf_pkg::*;
    `include "prime_factorizer_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_DIV   = 4'b0100,
        S_EVAL  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_num   r_rem,   n_rem;     // value still to factor
    t_num   r_div,   n_div;     // trial divisor
    t_num   r_acc,   n_acc;     // partial remainder
    t_num   r_sh,    n_sh;      // dividend in, quotient out
    t_cnt   r_cnt,   n_cnt;
    logic   r_ovalid, n_ovalid;
    t_num   r_ofactor, n_ofactor;
    logic   r_olast,  n_olast;

    logic                  w_ofree;
    logic [NUMBER_WIDTH:0] w_trial;
    logic [NUMBER_WIDTH:0] w_diff;
    logic                  w_qbit;

    assign w_ofree = !r_ovalid || o_fac.ready;
    assign w_trial = {r_acc, r_sh[NUMBER_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_qbit  = !w_diff[NUMBER_WIDTH];

    assign i_num.ready  = (r_state == S_IDLE);
    assign o_fac.valid  = r_ovalid;
    assign o_fac.factor = r_ofactor;
    assign o_fac.last   = r_olast;

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_div     = r_div;
        n_acc     = r_acc;
        n_sh      = r_sh;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid;
        n_ofactor = r_ofactor;
        n_olast   = r_olast;

        if (o_fac.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_num.valid) begin
                    n_rem   = i_num.number;
                    n_div   = t_num'(2);
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_rem <= t_num'(1)) begin
                    if (w_ofree) begin
                        n_ovalid  = 1'b1;
                        n_ofactor = '0;
                        n_olast   = 1'b1;
                        n_rem     = t_num'(1);
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_acc   = '0;
                    n_sh    = r_rem;
                    n_cnt   = t_cnt'(NUMBER_WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_acc = w_qbit ? w_diff[NUMBER_WIDTH-1:0] : w_trial[NUMBER_WIDTH-1:0];
                n_sh  = {r_sh[NUMBER_WIDTH-2:0], w_qbit};
                if (r_cnt == '0) begin
                    n_state = S_EVAL;
                end else begin
                    n_cnt = r_cnt - t_cnt'(1);
                end
            end
            S_EVAL: begin
                // divisor above quotient means divisor squared exceeds the value
                if (r_div > r_sh) begin
                    if (w_ofree) begin
                        n_ovalid  = 1'b1;
                        n_ofactor = r_rem;
                        n_olast   = 1'b1;
                        n_div     = r_rem;
                        n_rem     = t_num'(1);
                        n_state   = S_IDLE;
                    end
                end else if (r_acc == '0) begin
                    if (w_ofree) begin
                        n_ovalid  = 1'b1;
                        n_ofactor = r_div;
                        n_olast   = (r_sh == t_num'(1));
                        n_rem     = r_sh;
                        if (r_sh == t_num'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_acc   = '0;
                            n_cnt   = t_cnt'(NUMBER_WIDTH - 1);
                            n_state = S_DIV;
                        end
                    end
                end else begin
                    n_div   = r_div + t_num'(1);
                    n_acc   = '0;
                    n_sh    = r_rem;
                    n_cnt   = t_cnt'(NUMBER_WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_acc     <= n_acc;
        r_sh      <= n_sh;
        r_cnt     <= n_cnt;
        r_ofactor <= n_ofactor;
        r_olast   <= n_olast;
    end

    `PF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        i_num.valid && i_num.ready, r_state == S_START,
        "accepted number did not start a search")
    `PF_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n,
        r_state == S_EVAL, r_acc < r_div,
        "division remainder not below divisor")
    `PF_ASSERT_IMP(a_div_operands, i_clk, i_rst_n,
        r_state == S_DIV, (r_div >= t_num'(2)) && (r_rem >= t_num'(2)),
        "division with divisor or value below two")
    `PF_ASSERT_IMP(a_zero_is_last, i_clk, i_rst_n,
        r_ovalid && (r_ofactor == '0), r_olast,
        "zero factor without last mark")

endmodule

FILE: dv/tb_prime_factorizer.sv
// Testbench for prime_factorizer: directed and random numbers, factors checked in order.
module tb_prime_factorizer;
    import pf_pkg::*;

    localparam int MAX_FACTORS  = NUMBER_WIDTH - 1;
    localparam int RANDOM_ITEMS = 80;
    localparam int STALL_LIMIT  = 200_000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        t_num factor;
        logic last;
    } t_factor;

    // one directed row; typed rows carry their single expected factor
    typedef struct packed {
        t_num    number;
        logic    typed;
        t_factor result;
    } t_number_row;

    localparam int DIRECTED_ROWS = 20;

    t_number_row directed_rows [DIRECTED_ROWS] = '{
        '{14'd1,     1'b1, '{14'd0,     1'b1}},  // no prime factors
        '{14'd0,     1'b1, '{14'd0,     1'b1}},  // zero acts like one
        '{14'd2,     1'b1, '{14'd2,     1'b1}},
        '{14'd3,     1'b1, '{14'd3,     1'b1}},
        '{14'd16381, 1'b1, '{14'd16381, 1'b1}},  // largest prime in range
        '{14'd8191,  1'b1, '{14'd8191,  1'b1}},
        '{14'd16383, 1'b0, '{14'd0,     1'b0}},  // all ones
        '{14'd8192,  1'b0, '{14'd0,     1'b0}},  // 2^13: most factors
        '{14'd4,     1'b0, '{14'd0,     1'b0}},
        '{14'd12,    1'b0, '{14'd0,     1'b0}},
        '{14'd49,    1'b0, '{14'd0,     1'b0}},
        '{14'd16129, 1'b0, '{14'd0,     1'b0}},  // square of a prime
        '{14'd15625, 1'b0, '{14'd0,     1'b0}},
        '{14'd6561,  1'b0, '{14'd0,     1'b0}},
        '{14'd16382, 1'b0, '{14'd0,     1'b0}},
        '{14'd10010, 1'b0, '{14'd0,     1'b0}},
        '{14'd2310,  1'b0, '{14'd0,     1'b0}},
        '{14'd1,     1'b1, '{14'd0,     1'b1}},
        '{14'd9409,  1'b0, '{14'd0,     1'b0}},
        '{14'd15,    1'b0, '{14'd0,     1'b0}}
    };

    logic clk;
    logic rst_n;
    logic steady;  // no idling on either side while set
    int   mismatches = 0;
    int   quiet_cycles = 0;

    t_factor pending_factors [$];

    pf_num_if num_ch ();
    pf_fac_if fac_ch ();

    prime_factorizer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_num   (num_ch),
        .o_fac   (fac_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // trial division, same divisor kept after a hit
    function automatic void factorize(input t_num value);
        int unsigned remaining;
        int unsigned divisor;
        int          found;
        remaining = value;
        divisor   = 2;
        found     = 0;
        if (remaining <= 1) begin
            pending_factors.push_back('{t_num'(0), 1'b1});
            return;
        end
        while (remaining > 1 && found < MAX_FACTORS) begin
            if (divisor * divisor > remaining) begin
                pending_factors.push_back('{t_num'(remaining), 1'b1});
                remaining = 1;
                found++;
            end else if (remaining % divisor == 0) begin
                remaining = remaining / divisor;
                pending_factors.push_back('{t_num'(divisor), remaining == 1});
                found++;
            end else begin
                divisor++;
            end
        end
    endfunction

    task automatic send_number(input t_num value, input logic typed, input t_factor result);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 28) gap++;
        end
        if (gap > 0) begin
            num_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.number <= value;
        do @(posedge clk); while (!num_ch.ready);
        if (typed) begin
            pending_factors.push_back(result);
        end else begin
            factorize(value);
        end
    endtask

    always @(posedge clk) begin
        fac_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
    end

    always @(posedge clk) begin
        t_factor want;
        if (rst_n && fac_ch.valid && fac_ch.ready) begin
            if (pending_factors.size() == 0) begin
                $error("factor %0d (last %0b) with no factor expected",
                       fac_ch.factor, fac_ch.last);
                mismatches++;
            end else begin
                want = pending_factors.pop_front();
                if (fac_ch.factor !== want.factor) begin
                    $error("factor: expected %0d, got %0d", want.factor, fac_ch.factor);
                    mismatches++;
                end
                if (fac_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, fac_ch.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((num_ch.valid && num_ch.ready) || (fac_ch.valid && fac_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_num value;
        int   pick;
        steady        = 1'b0;
        rst_n         = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_number(directed_rows[i].number, directed_rows[i].typed,
                        directed_rows[i].result);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady <= (i >= 40 && i < 65);
            pick = $urandom_range(99);
            if (pick < 65) begin
                value = t_num'($urandom_range(255, 2));
            end else if (pick < 85) begin
                value = t_num'($urandom_range(16383, 1));
            end else if (pick < 95) begin
                value = t_num'(1) << $urandom_range(NUMBER_WIDTH - 1, 0);
            end else begin
                value = t_num'($urandom_range(1, 0));
            end
            send_number(value, 1'b0, '0);
        end
        num_ch.valid <= 1'b0;
        steady       <= 1'b0;

        while (pending_factors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_factors.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
